### rtl/core/curve_point_doubling_defines.svh
// Assertion macros shared by the point doubling RTL.
`ifndef CURVE_POINT_DOUBLING_DEFINES_SVH
`define CURVE_POINT_DOUBLING_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked outside reset
`define CPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on every edge, reset included
`define CPD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CPD_ASSERT(lbl, prop, msg)
`define CPD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/core/cpd_pkg.sv
package cpd_pkg;

  localparam int W               = 64;
  localparam int FRAC_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef logic signed [W-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(W-1){1'b0}}};

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ORDER2 = 2'd1;
  localparam logic [1:0] ST_OVF    = 2'd2;

  localparam logic [1:0] REG_A1 = 2'd0;
  localparam logic [1:0] REG_A3 = 2'd1;
  localparam logic [1:0] REG_A2 = 2'd2;
  localparam logic [1:0] REG_A4 = 2'd3;

  typedef struct packed {
    fx_t  v;
    logic o;
  } sat_t;

  // one item on its way through the back end
  typedef struct packed {
    logic vld;
    logic dz;
    logic ovf;
    fx_t  x;
    fx_t  y;
    fx_t  xx;
    fx_t  tt;
    fx_t  a1y;
    fx_t  a1x;
    fx_t  num;
    fx_t  den;
    fx_t  g;
    fx_t  c;
    fx_t  x2;
    fx_t  u;
    fx_t  x3;
    fx_t  y3;
  } wk_t;

  function automatic sat_t sat_add(fx_t a, fx_t b);
    logic [W:0] s;
    sat_t       r;
    s   = {a[W-1], a} + {b[W-1], b};
    r.o = s[W] ^ s[W-1];
    r.v = r.o ? (s[W] ? FX_MIN : FX_MAX) : $signed(s[W-1:0]);
    return r;
  endfunction

  function automatic sat_t sat_sub(fx_t a, fx_t b);
    logic [W:0] s;
    sat_t       r;
    s   = {a[W-1], a} - {b[W-1], b};
    r.o = s[W] ^ s[W-1];
    r.v = r.o ? (s[W] ? FX_MIN : FX_MAX) : $signed(s[W-1:0]);
    return r;
  endfunction

  function automatic sat_t sat_neg(fx_t a);
    sat_t r;
    r.o = (a == FX_MIN);
    r.v = r.o ? FX_MAX : -a;
    return r;
  endfunction

  function automatic logic [W-1:0] mag(fx_t a);
    logic [W-1:0] u;
    u = a;
    return a[W-1] ? (~u + 1'b1) : u;
  endfunction

endpackage

### rtl/core/cpd_front.sv
`include "curve_point_doubling_defines.svh"

module cpd_front import cpd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  fx_t  x_i,
  input  fx_t  y_i,
  output logic vld_o,
  output fx_t  x_o,
  output fx_t  y_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fx_t           qx_q [DEPTH];
  fx_t           qy_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign busy  = (cnt_q == CW'(DEPTH));
  assign push  = start && !busy;
  // the back end takes one item every cycle
  assign pop   = (cnt_q != '0);
  assign vld_o = pop;
  assign x_o   = qx_q[rd_q];
  assign y_o   = qy_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      qx_q[wr_q] <= x_i;
      qy_q[wr_q] <= y_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CW'(push) - CW'(pop);
    end
  end

  `CPD_ASSERT(a_push_shows, (push && cnt_q == '0) |=> vld_o, "pushed item not presented")
  `CPD_ASSERT(a_cnt_range, cnt_q <= CW'(DEPTH), "queue count beyond depth")

endmodule

### rtl/core/cpd_fx_mul.sv
module cpd_fx_mul import cpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  fx_t  a_i,
  input  fx_t  b_i,
  output fx_t  p_o,
  output logic ovf_o
);

  localparam int H = W / 2;

  logic [W-1:0]          ua, ub;
  logic [W-1:0]          ll_q, lh_q, hl_q, hh_q;
  logic                  neg1_q, neg2_q;
  logic [2*W-1:0]        sum_q;
  logic signed [2*W-1:0] prod, hi;
  logic                  ok;

  assign ua = mag(a_i);
  assign ub = mag(b_i);

  always_ff @(posedge clk_i) begin
    ll_q   <= ua[H-1:0] * ub[H-1:0];
    lh_q   <= ua[H-1:0] * ub[W-1:H];
    hl_q   <= ua[W-1:H] * ub[H-1:0];
    hh_q   <= ua[W-1:H] * ub[W-1:H];
    neg1_q <= a_i[W-1] ^ b_i[W-1];
    sum_q  <= {hh_q, ll_q} + {{H{1'b0}}, lh_q, {H{1'b0}}} + {{H{1'b0}}, hl_q, {H{1'b0}}};
    neg2_q <= neg1_q;
  end

  // drop fraction bits, saturate when the upper part is not a sign extension
  always_comb begin
    prod = neg2_q ? -$signed(sum_q) : $signed(sum_q);
    hi   = prod >>> (FRAC_BITS + W - 1);
    ok   = (hi == '0) || (hi == '1);
  end

  always_ff @(posedge clk_i) begin
    p_o   <= ok ? $signed(prod[FRAC_BITS+W-1:FRAC_BITS]) : (prod[2*W-1] ? FX_MIN : FX_MAX);
    ovf_o <= !ok;
  end

endmodule

### rtl/core/cpd_div.sv
module cpd_div import cpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  wk_t  side_i,
  input  fx_t  num_i,
  input  fx_t  den_i,
  output wk_t  side_o,
  output fx_t  g_o,
  output logic ovf_o
);

  localparam int DW = W + FRAC_BITS;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};

  wk_t           sd_q  [DW+1];
  logic [W-1:0]  ud_q  [DW+1];
  logic [W-1:0]  r_q   [DW+1];
  logic [W-1:0]  q_q   [DW+1];
  logic [DW-1:0] n_q   [DW+1];
  logic          qo_q  [DW+1];
  logic          neg_q [DW+1];
  logic          fin_ovf;
  fx_t           fin_g;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DW; i++) sd_q[i] <= '0;
    end else begin
      sd_q[0] <= side_i;
      for (int i = 0; i < DW; i++) sd_q[i+1] <= sd_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    ud_q[0]  <= mag(den_i);
    n_q[0]   <= {mag(num_i), {FRAC_BITS{1'b0}}};
    r_q[0]   <= '0;
    q_q[0]   <= '0;
    qo_q[0]  <= 1'b0;
    neg_q[0] <= num_i[W-1] ^ den_i[W-1];
  end

  // one restoring step per stage
  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [W-1:0] rp;
    logic         take;
    assign rp   = {r_q[i][W-2:0], n_q[i][DW-1]};
    assign take = (rp >= ud_q[i]);

    always_ff @(posedge clk_i) begin
      r_q[i+1]   <= take ? rp - ud_q[i] : rp;
      q_q[i+1]   <= {q_q[i][W-2:0], take};
      qo_q[i+1]  <= qo_q[i] | q_q[i][W-1];
      n_q[i+1]   <= n_q[i] << 1;
      ud_q[i+1]  <= ud_q[i];
      neg_q[i+1] <= neg_q[i];
    end
  end

  always_comb begin
    if (neg_q[DW]) begin
      fin_ovf = qo_q[DW] || (q_q[DW] > HALF);
      fin_g   = fin_ovf ? FX_MIN : $signed(~q_q[DW] + 1'b1);
    end else begin
      fin_ovf = qo_q[DW] || q_q[DW][W-1];
      fin_g   = fin_ovf ? FX_MAX : $signed(q_q[DW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_o <= '0;
    end else begin
      side_o <= sd_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    g_o   <= fin_g;
    ovf_o <= fin_ovf;
  end

endmodule

### rtl/core/cpd_back.sv
module cpd_back import cpd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fx_t        a1_i,
  input  fx_t        a3_i,
  input  fx_t        a2_i,
  input  fx_t        a4_i,
  input  logic       in_vld_i,
  input  fx_t        in_x_i,
  input  fx_t        in_y_i,
  output logic       done_o,
  output fx_t        x_doubled_o,
  output fx_t        y_doubled_o,
  output fx_t        slope_o,
  output logic [1:0] status_o
);

  wk_t  t0, f0;
  wk_t  tg_q [3];
  wk_t  e_d [5], e_q [5];
  wk_t  fg_q [3];
  wk_t  h_d [3], h_q [3];
  wk_t  jg_q [3];
  wk_t  j_d [2], j_q [2];
  wk_t  dv_side;
  fx_t  dv_g;
  logic dv_ovf;
  fx_t  mxx_p, mt_p, ma1y_p, ma1x_p, gg_p, a1g_p, gx_p, m_p;
  logic mxx_o, mt_o, ma1y_o, ma1x_o, gg_o, a1g_o, gx_o, m_o;
  sat_t so;

  always_comb begin
    t0     = '0;
    t0.vld = in_vld_i;
    t0.x   = in_x_i;
    t0.y   = in_y_i;
  end

  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mxx (
    .clk_i, .a_i(in_x_i), .b_i(in_x_i), .p_o(mxx_p), .ovf_o(mxx_o));
  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mt (
    .clk_i, .a_i(a2_i), .b_i(in_x_i), .p_o(mt_p), .ovf_o(mt_o));
  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_ma1y (
    .clk_i, .a_i(a1_i), .b_i(in_y_i), .p_o(ma1y_p), .ovf_o(ma1y_o));
  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_ma1x (
    .clk_i, .a_i(a1_i), .b_i(in_x_i), .p_o(ma1x_p), .ovf_o(ma1x_o));

  // numerator and denominator, one saturating step per stage in formula order
  always_comb begin
    sat_t sa, sb, sc;
    e_d[0]     = tg_q[2];
    sa         = sat_add(mxx_p, mxx_p);
    sb         = sat_add(mt_p, mt_p);
    sc         = sat_add(tg_q[2].y, tg_q[2].y);
    e_d[0].xx  = mxx_p;
    e_d[0].num = sa.v;
    e_d[0].tt  = sb.v;
    e_d[0].den = sc.v;
    e_d[0].a1y = ma1y_p;
    e_d[0].a1x = ma1x_p;
    e_d[0].ovf = mxx_o | mt_o | ma1y_o | ma1x_o | sa.o | sb.o | sc.o;

    e_d[1]     = e_q[0];
    sa         = sat_add(e_q[0].num, e_q[0].xx);
    sb         = sat_add(e_q[0].den, e_q[0].a1x);
    e_d[1].num = sa.v;
    e_d[1].den = sb.v;
    e_d[1].ovf = e_q[0].ovf | sa.o | sb.o;

    e_d[2]     = e_q[1];
    sa         = sat_add(e_q[1].num, e_q[1].tt);
    sb         = sat_add(e_q[1].den, a3_i);
    e_d[2].num = sa.v;
    e_d[2].den = sb.v;
    e_d[2].ovf = e_q[1].ovf | sa.o | sb.o;

    e_d[3]     = e_q[2];
    sa         = sat_add(e_q[2].num, a4_i);
    e_d[3].num = sa.v;
    e_d[3].ovf = e_q[2].ovf | sa.o;

    e_d[4]     = e_q[3];
    sa         = sat_sub(e_q[3].num, e_q[3].a1y);
    e_d[4].num = sa.v;
    e_d[4].dz  = (e_q[3].den == '0);
    e_d[4].ovf = e_q[3].ovf | sa.o;
  end

  cpd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni,
    .side_i(e_q[4]), .num_i(e_q[4].num), .den_i(e_q[4].den),
    .side_o(dv_side), .g_o(dv_g), .ovf_o(dv_ovf));

  always_comb begin
    sat_t sa, sb;
    f0     = dv_side;
    sa     = sat_add(dv_g, a1_i);
    sb     = sat_add(dv_side.x, dv_side.x);
    f0.g   = dv_g;
    f0.c   = sa.v;
    f0.x2  = sb.v;
    f0.ovf = dv_side.ovf | dv_ovf | sa.o | sb.o;
  end

  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_gg (
    .clk_i, .a_i(dv_g), .b_i(dv_g), .p_o(gg_p), .ovf_o(gg_o));
  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_a1g (
    .clk_i, .a_i(a1_i), .b_i(dv_g), .p_o(a1g_p), .ovf_o(a1g_o));
  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_gx (
    .clk_i, .a_i(dv_g), .b_i(dv_side.x), .p_o(gx_p), .ovf_o(gx_o));

  always_comb begin
    sat_t sa, sb;
    h_d[0]     = fg_q[2];
    sa         = sat_add(gg_p, a1g_p);
    sb         = sat_sub(fg_q[2].y, gx_p);
    h_d[0].x3  = sa.v;
    h_d[0].u   = sb.v;
    h_d[0].ovf = fg_q[2].ovf | gg_o | a1g_o | gx_o | sa.o | sb.o;

    h_d[1]     = h_q[0];
    sa         = sat_sub(h_q[0].x3, a2_i);
    h_d[1].x3  = sa.v;
    h_d[1].ovf = h_q[0].ovf | sa.o;

    h_d[2]     = h_q[1];
    sa         = sat_sub(h_q[1].x3, h_q[1].x2);
    h_d[2].x3  = sa.v;
    h_d[2].ovf = h_q[1].ovf | sa.o;
  end

  cpd_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_m (
    .clk_i, .a_i(h_q[2].c), .b_i(h_q[2].x3), .p_o(m_p), .ovf_o(m_o));

  always_comb begin
    sat_t sa;
    j_d[0]     = jg_q[2];
    sa         = sat_neg(m_p);
    j_d[0].y3  = sa.v;
    j_d[0].ovf = jg_q[2].ovf | m_o | sa.o;

    j_d[1]     = j_q[0];
    sa         = sat_sub(j_q[0].y3, j_q[0].u);
    j_d[1].y3  = sa.v;
    j_d[1].ovf = j_q[0].ovf | sa.o;
  end

  assign so = sat_sub(j_q[1].y3, a3_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        tg_q[i] <= '0;
        fg_q[i] <= '0;
        h_q[i]  <= '0;
        jg_q[i] <= '0;
      end
      for (int i = 0; i < 5; i++) e_q[i] <= '0;
      for (int i = 0; i < 2; i++) j_q[i] <= '0;
      done_o <= 1'b0;
    end else begin
      // tags ride alongside the multiplier pipes
      tg_q[0] <= t0;
      fg_q[0] <= f0;
      jg_q[0] <= h_q[2];
      for (int i = 0; i < 2; i++) begin
        tg_q[i+1] <= tg_q[i];
        fg_q[i+1] <= fg_q[i];
        jg_q[i+1] <= jg_q[i];
      end
      for (int i = 0; i < 5; i++) e_q[i] <= e_d[i];
      for (int i = 0; i < 3; i++) h_q[i] <= h_d[i];
      for (int i = 0; i < 2; i++) j_q[i] <= j_d[i];
      done_o <= j_q[1].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (j_q[1].dz) begin
      x_doubled_o <= '0;
      y_doubled_o <= '0;
      slope_o     <= '0;
      status_o    <= ST_ORDER2;
    end else begin
      x_doubled_o <= j_q[1].x3;
      y_doubled_o <= so.v;
      slope_o     <= j_q[1].g;
      status_o    <= (j_q[1].ovf | so.o) ? ST_OVF : ST_OK;
    end
  end

endmodule

### rtl/core/curve_point_doubling.sv
// Point doubling on a general Weierstrass curve, signed fixed point.
// Input: raise start with x_coord_i / y_coord_i; the point transfers at a
// rising edge where start is high and busy is low. busy rises only when the
// input queue is full, which a steady stream does not cause.
// Output: done_o is high for one cycle with x_doubled_o, y_doubled_o,
// slope_o and status_o; the receiver takes it in that cycle and cannot stall.
// Throughput: one point per cycle, set by the fully pipelined back end
// (three-stage multipliers, one quotient bit per divider stage).
// Most of the pipeline depth lies in the 64 + FRAC_BITS divider stages.
// Coefficients: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is
// high (0 a1, 1 a3, 2 a2, 3 a4); write only when no point is in flight.
// Reset: asynchronous, clears the queue, the pipeline valids and all
// coefficients to zero; no result is pending afterwards.
`include "curve_point_doubling_defines.svh"

module curve_point_doubling import cpd_pkg::*; #(
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  fx_t          x_coord_i,
  input  fx_t          y_coord_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [W-1:0] cfg_wdata_i,
  output logic         done_o,
  output fx_t          x_doubled_o,
  output fx_t          y_doubled_o,
  output fx_t          slope_o,
  output logic [1:0]   status_o
);

  fx_t  a1_q, a3_q, a2_q, a4_q;
  logic fr_vld;
  fx_t  fr_x, fr_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q <= '0;
      a3_q <= '0;
      a2_q <= '0;
      a4_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_A1:  a1_q <= $signed(cfg_wdata_i);
        REG_A3:  a3_q <= $signed(cfg_wdata_i);
        REG_A2:  a2_q <= $signed(cfg_wdata_i);
        REG_A4:  a4_q <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  cpd_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni, .start, .busy,
    .x_i(x_coord_i), .y_i(y_coord_i),
    .vld_o(fr_vld), .x_o(fr_x), .y_o(fr_y));

  cpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .a1_i(a1_q), .a3_i(a3_q), .a2_i(a2_q), .a4_i(a4_q),
    .in_vld_i(fr_vld), .in_x_i(fr_x), .in_y_i(fr_y),
    .done_o, .x_doubled_o, .y_doubled_o, .slope_o, .status_o);

  `CPD_ASSERT(a_order2_zero, (done_o && status_o == ST_ORDER2) |-> (slope_o == '0 && x_doubled_o == '0 && y_doubled_o == '0), "order-two result not zeroed")
  `CPD_ASSERT(a_status_code, done_o |-> (status_o == ST_OK || status_o == ST_ORDER2 || status_o == ST_OVF), "bad status code")

endmodule

### test/cpd_checker.sv
`timescale 1ns / 1ps

module cpd_checker import cpd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  input  logic         busy,
  input  fx_t          x_coord_i,
  input  fx_t          y_coord_i,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [W-1:0] cfg_wdata_i,
  input  logic         done_o,
  input  fx_t          x_doubled_o,
  input  fx_t          y_doubled_o,
  input  fx_t          slope_o,
  input  logic [1:0]   status_o,
  output int           n_fail,
  output int           n_pending,
  output int           n_points,
  output int           n_order2,
  output int           n_sat
);

  localparam int FB = FRAC_BITS_DEF;

  typedef struct {
    fx_t        xd;
    fx_t        yd;
    fx_t        g;
    logic [1:0] st;
  } dbl_t;

  dbl_t doubled_q[$];
  fx_t  c_a1, c_a3, c_a2, c_a4;
  bit   sat_seen;

  function automatic fx_t clamp(logic signed [129:0] v);
    if (v > 130'sd9223372036854775807) begin
      sat_seen = 1;
      return FX_MAX;
    end
    if (v < -130'sd9223372036854775808) begin
      sat_seen = 1;
      return FX_MIN;
    end
    return v[63:0];
  endfunction

  function automatic fx_t add_c(fx_t a, fx_t b);
    logic signed [129:0] s;
    s = 130'(a) + 130'(b);
    return clamp(s);
  endfunction

  function automatic fx_t sub_c(fx_t a, fx_t b);
    logic signed [129:0] s;
    s = 130'(a) - 130'(b);
    return clamp(s);
  endfunction

  function automatic fx_t mul_c(fx_t a, fx_t b);
    logic signed [129:0] p;
    p = (130'(a) * 130'(b)) >>> FB;
    return clamp(p);
  endfunction

  function automatic fx_t div_c(fx_t n, fx_t d);
    logic signed [129:0] q;
    q = (130'(n) <<< FB) / 130'(d);
    return clamp(q);
  endfunction

  function automatic dbl_t double_point(fx_t x, fx_t y);
    dbl_t r;
    fx_t  xx, num, den, t, g, x3, y3;
    sat_seen = 0;
    xx  = mul_c(x, x);
    num = add_c(add_c(xx, xx), xx);
    t   = mul_c(c_a2, x);
    num = add_c(num, add_c(t, t));
    num = add_c(num, c_a4);
    num = sub_c(num, mul_c(c_a1, y));
    den = add_c(y, y);
    den = add_c(den, mul_c(c_a1, x));
    den = add_c(den, c_a3);
    if (den == 0) begin
      r.xd = 0;
      r.yd = 0;
      r.g  = 0;
      r.st = ST_ORDER2;
      return r;
    end
    g  = div_c(num, den);
    x3 = mul_c(g, g);
    x3 = add_c(x3, mul_c(c_a1, g));
    x3 = sub_c(x3, c_a2);
    x3 = sub_c(x3, add_c(x, x));
    y3 = sub_c(0, mul_c(add_c(g, c_a1), x3));
    y3 = sub_c(y3, sub_c(y, mul_c(g, x)));
    y3 = sub_c(y3, c_a3);
    r.xd = x3;
    r.yd = y3;
    r.g  = g;
    r.st = sat_seen ? ST_OVF : ST_OK;
    return r;
  endfunction

  assign n_pending = doubled_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    dbl_t e;
    if (!rst_ni) begin
      c_a1 <= '0;
      c_a3 <= '0;
      c_a2 <= '0;
      c_a4 <= '0;
      n_fail = 0;
      n_points = 0;
      n_order2 = 0;
      n_sat = 0;
      doubled_q.delete();
    end else begin
      if (done_o) begin
        if (doubled_q.size() == 0) begin
          $error("unexpected result transfer");
          n_fail++;
        end else begin
          e = doubled_q.pop_front();
          if (x_doubled_o !== e.xd) begin
            $error("x_doubled exp %h got %h", e.xd, x_doubled_o);
            n_fail++;
          end
          if (y_doubled_o !== e.yd) begin
            $error("y_doubled exp %h got %h", e.yd, y_doubled_o);
            n_fail++;
          end
          if (slope_o !== e.g) begin
            $error("slope exp %h got %h", e.g, slope_o);
            n_fail++;
          end
          if (status_o !== e.st) begin
            $error("status exp %0d got %0d", e.st, status_o);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        e = double_point(x_coord_i, y_coord_i);
        doubled_q.push_back(e);
        n_points++;
        if (e.st == ST_ORDER2) n_order2++;
        if (e.st == ST_OVF) n_sat++;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_A1: c_a1 <= cfg_wdata_i;
          REG_A3: c_a3 <= cfg_wdata_i;
          REG_A2: c_a2 <= cfg_wdata_i;
          REG_A4: c_a4 <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import cpd_pkg::*;

  localparam int LATENCY = 86 + FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam fx_t ONE = 64'sh1_0000_0000;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         start = 0;
  logic         busy;
  fx_t          x_coord_i = '0;
  fx_t          y_coord_i = '0;
  logic         cfg_we_i = 0;
  logic [1:0]   cfg_idx_i = '0;
  logic [W-1:0] cfg_wdata_i = '0;
  logic         done_o;
  fx_t          x_doubled_o, y_doubled_o, slope_o;
  logic [1:0]   status_o;
  int           n_fail, n_pending, n_points, n_order2, n_sat;
  int           idle_cycles = 0;
  int           n_cfg = 0;

  curve_point_doubling i_dut (.*);

  cpd_checker i_chk (.*);

  initial forever #5 clk_i = ~clk_i;

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("curve_point_doubling test failed");
      $finish;
    end
  end

  function automatic fx_t rand_fx();
    fx_t v;
    case ($urandom_range(0, 9))
      0: v = {$urandom, $urandom};
      1: v = FX_MAX;
      2: v = FX_MIN;
      3: v = 0;
      4: v = $signed({$urandom, $urandom}) >>> $urandom_range(0, 63);
      default: v = $signed({$urandom, $urandom}) >>> $urandom_range(20, 34);
    endcase
    return v;
  endfunction

  // leaves start high so that points can follow back to back
  task automatic send_point(fx_t x, fx_t y);
    start <= 1;
    x_coord_i <= x;
    y_coord_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic send_burst(int n);
    repeat (n) begin
      send_point(rand_fx(), rand_fx());
    end
    start <= 0;
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 12)) @(posedge clk_i);
  endtask

  task automatic drain();
    while (n_pending != 0) @(posedge clk_i);
    repeat (LATENCY + 8) @(posedge clk_i);
  endtask

  task automatic write_coef(logic [1:0] idx, fx_t v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    n_cfg++;
  endtask

  task automatic set_curve(fx_t a1, fx_t a3, fx_t a2, fx_t a4);
    write_coef(REG_A1, a1);
    write_coef(REG_A3, a3);
    write_coef(REG_A2, a2);
    write_coef(REG_A4, a4);
    cfg_we_i <= 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: default curve y^2 = x^3
    send_point(0, 0);
    send_point(ONE, 0);
    send_point(ONE, ONE);
    send_point(FX_MAX, FX_MAX);
    send_point(FX_MIN, FX_MIN);
    send_point(FX_MAX, FX_MIN);
    send_point(FX_MIN, ONE);
    send_point(2 * ONE, -3 * ONE);
    send_point(-1, 1);
    send_point(ONE, FX_MAX);
    start <= 0;
    drain();
    set_curve(ONE, -2 * ONE, 3 * ONE, -ONE);
    // den = 2y + x + a3 hits zero
    send_point(0, ONE);
    send_point(2 * ONE, 0);
    send_point(ONE, ONE >>> 1);
    send_point(FX_MAX, FX_MAX);
    send_point(FX_MIN, 5 * ONE);
    start <= 0;
    drain();
    set_curve(FX_MAX, FX_MIN, FX_MIN, FX_MAX);
    send_point(ONE, ONE);
    send_point(0, 0);
    send_point(FX_MIN, FX_MAX);
    start <= 0;
    drain();
    set_curve(FX_MIN, FX_MAX, FX_MAX, FX_MIN);
    send_point(ONE, -ONE);
    send_point(0, 3);
    start <= 0;
    drain();

    // random phases, each with its own curve
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) set_curve(0, 0, 0, 0);
      else set_curve(rand_fx(), rand_fx(), rand_fx(), rand_fx());
      while (n_points < 25 + (ph + 1) * 160) begin
        send_burst($urandom_range(1, 40));
        // hold until the pipeline empties now and then
        if ($urandom_range(0, 15) == 0) while (n_pending != 0) @(posedge clk_i);
      end
      drain();
    end

    drain();
    $display("covered %0d points, %0d order-two, %0d saturated, %0d coefficient writes",
             n_points, n_order2, n_sat, n_cfg);
    if (n_fail == 0) $display("curve_point_doubling test passed");
    else $display("curve_point_doubling test failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/cpd_pkg.sv
rtl/core/cpd_front.sv
rtl/core/cpd_fx_mul.sv
rtl/core/cpd_div.sv
rtl/core/cpd_back.sv
rtl/core/curve_point_doubling.sv
test/cpd_checker.sv
test/tb.sv
